// ===== sv/vsbp_pkg.sv =====
// Package for the VOC stream block parser.
// Holds codes, limits, the file signature and small lookup functions.
// No dependencies.
package vsbp_pkg;

   localparam int MAX_CHANNELS_DEF = 64;

   localparam logic [1:0] KIND_AUDIO  = 2'd0;
   localparam logic [1:0] KIND_FORMAT = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   localparam logic [2:0] ERR_CORRUPT = 3'd0;
   localparam logic [2:0] ERR_COMPR   = 3'd1;
   localparam logic [2:0] ERR_BITS    = 3'd2;
   localparam logic [2:0] ERR_CHAN    = 3'd3;
   localparam logic [2:0] ERR_HEADER  = 3'd4;

   localparam logic [3:0] CODEC_U8     = 4'd0;
   localparam logic [3:0] CODEC_ADPCM4 = 4'd1;
   localparam logic [3:0] CODEC_ADPCM3 = 4'd2;
   localparam logic [3:0] CODEC_ADPCM2 = 4'd3;
   localparam logic [3:0] CODEC_S16LE  = 4'd4;
   localparam logic [3:0] CODEC_ALAW   = 4'd5;
   localparam logic [3:0] CODEC_MULAW  = 4'd6;
   localparam logic [3:0] CODEC_U16LE  = 4'd7;
   localparam logic [3:0] CODEC_S8     = 4'd8;

   localparam logic [7:0] BK_END     = 8'd0;
   localparam logic [7:0] BK_SOUND   = 8'd1;
   localparam logic [7:0] BK_CONT    = 8'd2;
   localparam logic [7:0] BK_SILENCE = 8'd3;
   localparam logic [7:0] BK_EXT     = 8'd8;
   localparam logic [7:0] BK_NEW     = 8'd9;

   localparam logic [15:0] VER_OLD  = 16'h010A;
   localparam logic [15:0] VER_NEW  = 16'h0114;
   localparam logic [15:0] CHK_BASE = 16'h1234;
   localparam logic [15:0] HDR_LEN  = 16'd26;

   localparam logic [27:0] CLK_OLD  = 28'd1000000;
   localparam logic [27:0] CLK_EXT  = 28'd256000000;
   localparam logic [31:0] RATE_MAX = 32'd768000;

   localparam int DIV_STEPS = 28;
   localparam int DIV_CNT_W = 5;

   localparam logic [7:0] SIGNATURE [20] = '{
      8'h43, 8'h72, 8'h65, 8'h61, 8'h74, 8'h69, 8'h76, 8'h65, 8'h20, 8'h56,
      8'h6F, 8'h69, 8'h63, 8'h65, 8'h20, 8'h46, 8'h69, 8'h6C, 8'h65, 8'h1A
   };

   typedef struct packed {
      logic       start;
   } div_ctl_type;

   typedef struct packed {
      logic       busy;
      logic       done;
   } div_sts_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] codec;
      logic [7:0] bpf;
      logic [8:0] bits;
   } t1_fmt_type;

   function automatic t1_fmt_type t1_format(input logic [7:0] id);
      t1_fmt_type f;
      f = '{ok: 1'b1, codec: CODEC_U8, bpf: 8'd1, bits: 9'd8};
      case (id)
         8'd0: f = '{ok: 1'b1, codec: CODEC_U8,     bpf: 8'd1, bits: 9'd8};
         8'd1: f = '{ok: 1'b1, codec: CODEC_ADPCM4, bpf: 8'd1, bits: 9'd4};
         8'd2: f = '{ok: 1'b1, codec: CODEC_ADPCM3, bpf: 8'd3, bits: 9'd3};
         8'd3: f = '{ok: 1'b1, codec: CODEC_ADPCM2, bpf: 8'd1, bits: 9'd2};
         8'd4: f = '{ok: 1'b1, codec: CODEC_S16LE,  bpf: 8'd2, bits: 9'd16};
         8'd6: f = '{ok: 1'b1, codec: CODEC_ALAW,   bpf: 8'd1, bits: 9'd8};
         8'd7: f = '{ok: 1'b1, codec: CODEC_MULAW,  bpf: 8'd1, bits: 9'd8};
         default: f.ok = 1'b0;
      endcase
      return f;
   endfunction

   function automatic logic [27:0] fix_rate(input logic [27:0] r);
      logic [27:0] v;
      v = r;
      case (r)
         28'd11111: v = 28'd11025;
         28'd22222: v = 28'd22050;
         28'd44444: v = 28'd44100;
         default:   v = r;
      endcase
      return v;
   endfunction

endpackage

// ===== sv/vsbp_divider.sv =====
// Restoring divider, one quotient bit per cycle, for sample rate work.
// Depends on vsbp_pkg.
module vsbp_divider
   import vsbp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_ctl_type ctl,
   input  logic [27:0] dividend,
   input  logic [21:0] divisor,
   output div_sts_type sts,
   output logic [27:0] quotient
);

   logic [27:0]          quo_ff, quo_in;
   logic [21:0]          rem_ff, rem_in;
   logic [21:0]          dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [22:0]          trial;
   logic                 ge;

   assign trial = {rem_ff, quo_ff[27]};
   assign ge    = trial >= {1'b0, dvs_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? 22'(trial - {1'b0, dvs_ff}) : trial[21:0];
         quo_in = {quo_ff[26:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== sv/voc_stream_block_parser.sv =====
// Top level of the VOC stream block parser: byte parser, sequencer, output register.
// Depends on vsbp_pkg and vsbp_divider.
//
// The req_ channel takes the file one byte per transfer, file header first.
// The rsp_ channel gives at most one result per input byte: an audio byte,
// a format announcement or an error, in file order.
// Audio bytes flow one per cycle through the output register
// while the receiver keeps up.
// The last parameter byte of a sound or silence block starts the shared rate
// sequencer: a divide step (28 quotient bits, then the result is picked up),
// a multiply step for the bitrate and a step to load the announcement; an
// extended block needs only the divide step. A new block header byte is taken
// after that.
// A continuation block skips to the announcement, a new-format block to the multiply.
// Reset clears the parser to the start of a file and drops any pending result.
// When the receiver stalls, the result waits in the output register and
// req_ready falls until it is taken. After an error one error result is given
// and every later byte is taken and dropped until reset.
module voc_stream_block_parser
   import vsbp_pkg::*;
#(
   parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_byte_value,
   output logic        rsp_last_of_block,
   output logic [3:0]  rsp_codec,
   output logic [6:0]  rsp_channels,
   output logic [27:0] rsp_sample_rate,
   output logic [8:0]  rsp_bits_per_sample,
   output logic [7:0]  rsp_bytes_per_frame,
   output logic [30:0] rsp_bit_rate,
   output logic [15:0] rsp_silence_frames,
   output logic        rsp_format_changed,
   output logic [2:0]  rsp_error_code
);

   typedef enum logic [7:0] {
      PH_FILE  = 8'b0000_0001,
      PH_FSKIP = 8'b0000_0010,
      PH_BLK   = 8'b0000_0100,
      PH_PAR   = 8'b0000_1000,
      PH_XHDR  = 8'b0001_0000,
      PH_XPAR  = 8'b0010_0000,
      PH_SKIP  = 8'b0100_0000,
      PH_DATA  = 8'b1000_0000
   } phase_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_MUL  = 4'b0100,
      ST_EMIT = 4'b1000
   } seq_type;

   phase_type   phase_ff, phase_in;
   seq_type     st_ff, st_in;
   logic [15:0] cnt_ff, cnt_in;
   logic [15:0] start_ff, start_in;
   logic        sig_bad_ff, sig_bad_in;
   logic [7:0]  hb_ff [12];
   logic [7:0]  hb_in [12];
   logic [7:0]  hv [12];
   logic [7:0]  kind_ff, kind_in;
   logic [23:0] left_ff, left_in;
   logic        have_ff, have_in;
   logic        halted_ff, halted_in;

   logic [3:0]  cur_codec_ff, cur_codec_in;
   logic [6:0]  cur_ch_ff, cur_ch_in;
   logic [27:0] cur_rate_ff, cur_rate_in;
   logic [8:0]  cur_bits_ff, cur_bits_in;
   logic [7:0]  cur_bpf_ff, cur_bpf_in;
   logic [30:0] cur_brate_ff, cur_brate_in;

   logic [3:0]  nx_codec_ff, nx_codec_in;
   logic [6:0]  nx_ch_ff, nx_ch_in;
   logic [27:0] nx_rate_ff, nx_rate_in;
   logic [8:0]  nx_bits_ff, nx_bits_in;
   logic [7:0]  nx_bpf_ff, nx_bpf_in;
   logic [30:0] nx_brate_ff, nx_brate_in;
   logic [15:0] nx_sil_ff, nx_sil_in;

   logic [27:0] mul_a_ff, mul_a_in;
   logic [11:0] mul_b_ff, mul_b_in;
   logic [39:0] mul_prod;

   logic        out_valid_ff, out_valid_in;
   logic [1:0]  o_kind_ff, o_kind_in;
   logic [7:0]  o_byte_ff, o_byte_in;
   logic        o_last_ff, o_last_in;
   logic [3:0]  o_codec_ff, o_codec_in;
   logic [6:0]  o_ch_ff, o_ch_in;
   logic [27:0] o_rate_ff, o_rate_in;
   logic [8:0]  o_bits_ff, o_bits_in;
   logic [7:0]  o_bpf_ff, o_bpf_in;
   logic [30:0] o_brate_ff, o_brate_in;
   logic [15:0] o_sil_ff, o_sil_in;
   logic        o_chg_ff, o_chg_in;
   logic [2:0]  o_err_ff, o_err_in;

   div_ctl_type div_ctl;
   div_sts_type div_sts;
   logic [27:0] div_dividend;
   logic [21:0] div_divisor;
   logic [27:0] div_quo;

   logic        out_free;
   logic        accept;
   logic [7:0]  b;
   logic [3:0]  fidx;
   logic [15:0] f_off, f_ver, f_chk, f_want;
   logic [23:0] size;
   logic [16:0] tc_span;
   logic [5:0]  x_ch;
   logic [22:0] x_div;
   logic [31:0] r9;
   logic [15:0] fmt9;
   logic [8:0]  bpf9;
   logic [27:0] fixed_q;
   logic        chg;
   t1_fmt_type  t1;

   vsbp_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .sts      (div_sts),
      .quotient (div_quo)
   );

   assign out_free  = !out_valid_ff || rsp_ready;
   assign req_ready = (st_ff == ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign b         = req_data_byte;
   assign fidx      = cnt_ff[3:0] - 4'd4;
   assign mul_prod  = mul_a_ff * mul_b_ff;
   assign fixed_q   = fix_rate(div_quo);

   always_comb begin
      for (int i = 0; i < 12; i++) begin
         hv[i] = (cnt_ff[3:0] == 4'(i)) ? b : hb_ff[i];
      end
   end

   assign f_off   = {hb_ff[1], hb_ff[0]};
   assign f_ver   = {hb_ff[3], hb_ff[2]};
   assign f_chk   = {b, hb_ff[4]};
   assign f_want  = CHK_BASE + ~f_ver;
   assign size    = {hv[3], hv[2], hv[1]};
   assign tc_span = 17'h10000 - {1'b0, hv[1], hv[0]};
   assign x_ch    = {1'b0, hv[3][4:0]} + 6'd1;
   assign x_div   = tc_span * x_ch;
   assign r9      = {hv[3], hv[2], hv[1], hv[0]};
   assign fmt9    = {hv[7], hv[6]};
   assign bpf9    = (hv[4] == 8'd16) ? {hv[5], 1'b0} : {1'b0, hv[5]};
   assign t1      = t1_format(hv[1]);
   assign chg     = !have_ff || nx_bits_ff != cur_bits_ff || nx_rate_ff != cur_rate_ff
                    || nx_ch_ff != cur_ch_ff;

   always_comb begin
      phase_in     = phase_ff;
      st_in        = st_ff;
      cnt_in       = cnt_ff;
      start_in     = start_ff;
      sig_bad_in   = sig_bad_ff;
      hb_in        = hb_ff;
      kind_in      = kind_ff;
      left_in      = left_ff;
      have_in      = have_ff;
      halted_in    = halted_ff;
      cur_codec_in = cur_codec_ff;
      cur_ch_in    = cur_ch_ff;
      cur_rate_in  = cur_rate_ff;
      cur_bits_in  = cur_bits_ff;
      cur_bpf_in   = cur_bpf_ff;
      cur_brate_in = cur_brate_ff;
      nx_codec_in  = nx_codec_ff;
      nx_ch_in     = nx_ch_ff;
      nx_rate_in   = nx_rate_ff;
      nx_bits_in   = nx_bits_ff;
      nx_bpf_in    = nx_bpf_ff;
      nx_brate_in  = nx_brate_ff;
      nx_sil_in    = nx_sil_ff;
      mul_a_in     = mul_a_ff;
      mul_b_in     = mul_b_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      o_kind_in    = o_kind_ff;
      o_byte_in    = o_byte_ff;
      o_last_in    = o_last_ff;
      o_codec_in   = o_codec_ff;
      o_ch_in      = o_ch_ff;
      o_rate_in    = o_rate_ff;
      o_bits_in    = o_bits_ff;
      o_bpf_in     = o_bpf_ff;
      o_brate_in   = o_brate_ff;
      o_sil_in     = o_sil_ff;
      o_chg_in     = o_chg_ff;
      o_err_in     = o_err_ff;
      div_ctl.start = 1'b0;
      div_dividend  = CLK_OLD;
      div_divisor   = '0;

      case (st_ff)
         ST_IDLE: begin
            if (accept && !halted_ff) begin
               case (phase_ff)
                  PH_FILE: begin
                     if (cnt_ff < 16'd20) begin
                        if (b != SIGNATURE[cnt_ff[4:0]]) begin
                           sig_bad_in = 1'b1;
                        end
                     end else begin
                        hb_in[fidx] = b;
                     end
                     cnt_in = cnt_ff + 16'd1;
                     if (cnt_ff == 16'd25) begin
                        if (sig_bad_ff || f_off < HDR_LEN || (f_ver != VER_OLD &&
                            f_ver != VER_NEW) || f_chk != f_want) begin
                           halted_in    = 1'b1;
                           out_valid_in = 1'b1;
                           o_kind_in    = KIND_ERROR;
                           o_err_in     = ERR_HEADER;
                        end else begin
                           start_in = f_off;
                           if (f_off == HDR_LEN) begin
                              phase_in = PH_BLK;
                              cnt_in   = '0;
                           end else begin
                              phase_in = PH_FSKIP;
                           end
                        end
                     end
                  end
                  PH_FSKIP: begin
                     cnt_in = cnt_ff + 16'd1;
                     if (cnt_ff + 16'd1 >= start_ff) begin
                        phase_in = PH_BLK;
                        cnt_in   = '0;
                     end
                  end
                  PH_BLK, PH_XHDR: begin
                     hb_in[cnt_ff[1:0]] = b;
                     cnt_in = cnt_ff + 16'd1;
                     if (cnt_ff == 16'd3) begin
                        cnt_in = '0;
                        if (phase_ff == PH_XHDR) begin
                           if (size < 24'd2) begin
                              halted_in = 1'b1;
                           end else begin
                              left_in  = size - 24'd2;
                              phase_in = PH_XPAR;
                           end
                        end else begin
                           kind_in   = hv[0];
                           nx_sil_in = '0;
                           case (hv[0])
                              BK_END: halted_in = 1'b1;
                              BK_SOUND: begin
                                 if (size < 24'd2) begin
                                    halted_in = 1'b1;
                                 end else begin
                                    left_in  = size - 24'd2;
                                    phase_in = PH_PAR;
                                 end
                              end
                              BK_CONT: begin
                                 if (!have_ff) begin
                                    halted_in = 1'b1;
                                 end else begin
                                    nx_codec_in = cur_codec_ff;
                                    nx_ch_in    = cur_ch_ff;
                                    nx_rate_in  = cur_rate_ff;
                                    nx_bits_in  = cur_bits_ff;
                                    nx_bpf_in   = cur_bpf_ff;
                                    nx_brate_in = cur_brate_ff;
                                    left_in     = size;
                                    st_in       = ST_EMIT;
                                 end
                              end
                              BK_SILENCE, BK_EXT: begin
                                 if (size != ((hv[0] == BK_EXT) ? 24'd4 : 24'd3)) begin
                                    halted_in = 1'b1;
                                 end else begin
                                    left_in  = '0;
                                    phase_in = PH_PAR;
                                 end
                              end
                              BK_NEW: begin
                                 if (size < 24'd12) begin
                                    halted_in = 1'b1;
                                 end else begin
                                    left_in  = size - 24'd12;
                                    phase_in = PH_PAR;
                                 end
                              end
                              default: begin
                                 left_in  = size;
                                 phase_in = (size != '0) ? PH_SKIP : PH_BLK;
                              end
                           endcase
                        end
                        if (halted_in) begin
                           out_valid_in = 1'b1;
                           o_kind_in    = KIND_ERROR;
                           o_err_in     = ERR_CORRUPT;
                        end
                     end
                  end
                  PH_PAR: begin
                     hb_in[cnt_ff[3:0]] = b;
                     cnt_in = cnt_ff + 16'd1;
                     o_err_in = ERR_CORRUPT;
                     if ((kind_ff == BK_SOUND && cnt_ff == 16'd1) ||
                         (kind_ff == BK_SILENCE && cnt_ff == 16'd2) ||
                         (kind_ff == BK_EXT && cnt_ff == 16'd3) ||
                         (kind_ff == BK_NEW && cnt_ff == 16'd11)) begin
                        cnt_in = '0;
                        case (kind_ff)
                           BK_SOUND: begin
                              if (!t1.ok) begin
                                 halted_in = 1'b1;
                                 o_err_in  = ERR_COMPR;
                              end else begin
                                 nx_codec_in   = t1.codec;
                                 nx_bpf_in     = t1.bpf;
                                 nx_bits_in    = t1.bits;
                                 nx_ch_in      = 7'd1;
                                 div_ctl.start = 1'b1;
                                 div_divisor   = {13'd0, 9'h100 - {1'b0, hv[0]}};
                                 st_in         = ST_DIV;
                              end
                           end
                           BK_SILENCE: begin
                              nx_sil_in     = {hv[1], hv[0]};
                              nx_codec_in   = CODEC_U8;
                              nx_ch_in      = 7'd1;
                              nx_bits_in    = 9'd8;
                              nx_bpf_in     = 8'd1;
                              left_in       = '0;
                              div_ctl.start = 1'b1;
                              div_divisor   = {13'd0, 9'h100 - {1'b0, hv[2]}};
                              st_in         = ST_DIV;
                           end
                           BK_EXT: begin
                              if (hv[2] != 8'd0) begin
                                 halted_in = 1'b1;
                                 o_err_in  = ERR_COMPR;
                              end else if (hv[3] >= 8'd32) begin
                                 halted_in = 1'b1;
                              end else begin
                                 nx_ch_in      = {1'b0, x_ch};
                                 nx_codec_in   = CODEC_U8;
                                 nx_bpf_in     = {2'd0, x_ch};
                                 nx_bits_in    = {x_ch, 3'd0};
                                 div_ctl.start = 1'b1;
                                 div_dividend  = CLK_EXT;
                                 div_divisor   = x_div[21:0];
                                 st_in         = ST_DIV;
                              end
                           end
                           default: begin
                              if (r9 == '0 || r9 > RATE_MAX) begin
                                 halted_in = 1'b1;
                              end else if (fmt9 != 16'd0 && fmt9 != 16'd4) begin
                                 halted_in = 1'b1;
                                 o_err_in  = ERR_COMPR;
                              end else if (hv[4] != 8'd8 && hv[4] != 8'd16) begin
                                 halted_in = 1'b1;
                                 o_err_in  = ERR_BITS;
                              end else if (hv[5] == 8'd0 ||
                                           {1'b0, hv[5]} > 9'(MAX_CHANNELS)) begin
                                 halted_in = 1'b1;
                                 o_err_in  = ERR_CHAN;
                              end else begin
                                 if (fmt9 == 16'd0) begin
                                    nx_codec_in = (hv[4] == 8'd8) ? CODEC_U8 : CODEC_U16LE;
                                 end else begin
                                    nx_codec_in = (hv[4] == 8'd8) ? CODEC_S8 : CODEC_S16LE;
                                 end
                                 nx_rate_in = r9[27:0];
                                 nx_bits_in = {1'b0, hv[4]};
                                 nx_ch_in   = hv[5][6:0];
                                 nx_bpf_in  = bpf9[7:0];
                                 mul_a_in   = r9[27:0];
                                 mul_b_in   = {bpf9, 3'd0};
                                 st_in      = ST_MUL;
                              end
                           end
                        endcase
                        if (halted_in) begin
                           out_valid_in = 1'b1;
                           o_kind_in    = KIND_ERROR;
                        end
                     end
                  end
                  PH_XPAR: begin
                     hb_in[cnt_ff[0]] = b;
                     cnt_in = cnt_ff + 16'd1;
                     if (cnt_ff == 16'd1) begin
                        cnt_in = '0;
                        if (b != 8'd0) begin
                           halted_in    = 1'b1;
                           out_valid_in = 1'b1;
                           o_kind_in    = KIND_ERROR;
                           o_err_in     = ERR_COMPR;
                        end else begin
                           nx_sil_in = '0;
                           st_in     = ST_EMIT;
                        end
                     end
                  end
                  PH_SKIP: begin
                     left_in = left_ff - 24'd1;
                     if (left_ff <= 24'd1) begin
                        left_in  = '0;
                        phase_in = PH_BLK;
                     end
                  end
                  PH_DATA: begin
                     out_valid_in = 1'b1;
                     o_kind_in    = KIND_AUDIO;
                     o_byte_in    = b;
                     o_last_in    = 1'b0;
                     left_in      = left_ff - 24'd1;
                     if (left_ff <= 24'd1) begin
                        left_in   = '0;
                        o_last_in = 1'b1;
                        phase_in  = PH_BLK;
                     end
                  end
                  default: begin
                     phase_in = PH_BLK;
                     cnt_in   = '0;
                  end
               endcase
               if (out_valid_in && o_kind_in != KIND_FORMAT) begin
                  o_codec_in = '0;
                  o_ch_in    = '0;
                  o_rate_in  = '0;
                  o_bits_in  = '0;
                  o_bpf_in   = '0;
                  o_brate_in = '0;
                  o_sil_in   = '0;
                  o_chg_in   = 1'b0;
                  if (o_kind_in == KIND_ERROR) begin
                     o_byte_in = '0;
                     o_last_in = 1'b0;
                  end else begin
                     o_err_in = '0;
                  end
               end
            end
         end
         ST_DIV: begin
            if (div_sts.done) begin
               if (kind_ff == BK_EXT) begin
                  nx_rate_in  = div_quo;
                  nx_brate_in = {div_quo, 3'd0};
                  phase_in    = PH_XHDR;
                  st_in       = ST_IDLE;
               end else begin
                  nx_rate_in = fixed_q;
                  mul_a_in   = fixed_q;
                  mul_b_in   = {3'd0, nx_bits_ff};
                  st_in      = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            nx_brate_in = mul_prod[30:0];
            st_in       = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               st_in = ST_IDLE;
               if (left_ff == '0 && nx_sil_ff == '0) begin
                  phase_in = PH_BLK;
               end else begin
                  cur_codec_in = nx_codec_ff;
                  cur_ch_in    = nx_ch_ff;
                  cur_rate_in  = nx_rate_ff;
                  cur_bits_in  = nx_bits_ff;
                  cur_bpf_in   = nx_bpf_ff;
                  cur_brate_in = nx_brate_ff;
                  have_in      = 1'b1;
                  out_valid_in = 1'b1;
                  o_kind_in    = KIND_FORMAT;
                  o_byte_in    = '0;
                  o_last_in    = 1'b0;
                  o_codec_in   = nx_codec_ff;
                  o_ch_in      = nx_ch_ff;
                  o_rate_in    = nx_rate_ff;
                  o_bits_in    = nx_bits_ff;
                  o_bpf_in     = nx_bpf_ff;
                  o_brate_in   = nx_brate_ff;
                  o_sil_in     = nx_sil_ff;
                  o_chg_in     = chg;
                  o_err_in     = '0;
                  phase_in     = (left_ff != '0) ? PH_DATA : PH_BLK;
               end
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      hb_ff        <= hb_in;
      nx_codec_ff  <= nx_codec_in;
      nx_ch_ff     <= nx_ch_in;
      nx_rate_ff   <= nx_rate_in;
      nx_bits_ff   <= nx_bits_in;
      nx_bpf_ff    <= nx_bpf_in;
      nx_brate_ff  <= nx_brate_in;
      mul_a_ff     <= mul_a_in;
      mul_b_ff     <= mul_b_in;
      o_kind_ff    <= o_kind_in;
      o_byte_ff    <= o_byte_in;
      o_last_ff    <= o_last_in;
      o_codec_ff   <= o_codec_in;
      o_ch_ff      <= o_ch_in;
      o_rate_ff    <= o_rate_in;
      o_bits_ff    <= o_bits_in;
      o_bpf_ff     <= o_bpf_in;
      o_brate_ff   <= o_brate_in;
      o_sil_ff     <= o_sil_in;
      o_chg_ff     <= o_chg_in;
      o_err_ff     <= o_err_in;
      if (reset) begin
         phase_ff     <= PH_FILE;
         st_ff        <= ST_IDLE;
         cnt_ff       <= '0;
         start_ff     <= '0;
         sig_bad_ff   <= 1'b0;
         kind_ff      <= '0;
         left_ff      <= '0;
         have_ff      <= 1'b0;
         halted_ff    <= 1'b0;
         cur_codec_ff <= '0;
         cur_ch_ff    <= '0;
         cur_rate_ff  <= '0;
         cur_bits_ff  <= '0;
         cur_bpf_ff   <= '0;
         cur_brate_ff <= '0;
         nx_sil_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         st_ff        <= st_in;
         cnt_ff       <= cnt_in;
         start_ff     <= start_in;
         sig_bad_ff   <= sig_bad_in;
         kind_ff      <= kind_in;
         left_ff      <= left_in;
         have_ff      <= have_in;
         halted_ff    <= halted_in;
         cur_codec_ff <= cur_codec_in;
         cur_ch_ff    <= cur_ch_in;
         cur_rate_ff  <= cur_rate_in;
         cur_bits_ff  <= cur_bits_in;
         cur_bpf_ff   <= cur_bpf_in;
         cur_brate_ff <= cur_brate_in;
         nx_sil_ff    <= nx_sil_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_kind            = o_kind_ff;
   assign rsp_byte_value      = o_byte_ff;
   assign rsp_last_of_block   = o_last_ff;
   assign rsp_codec           = o_codec_ff;
   assign rsp_channels        = o_ch_ff;
   assign rsp_sample_rate     = o_rate_ff;
   assign rsp_bits_per_sample = o_bits_ff;
   assign rsp_bytes_per_frame = o_bpf_ff;
   assign rsp_bit_rate        = o_brate_ff;
   assign rsp_silence_frames  = o_sil_ff;
   assign rsp_format_changed  = o_chg_ff;
   assign rsp_error_code      = o_err_ff;

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> st_ff == ST_IDLE)
      else $error("input ready while the rate sequencer is busy");

   a_div_in_div: assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> st_ff == ST_DIV)
      else $error("divider finished outside the divide step");

   a_err_halts: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_ERROR) |-> halted_ff)
      else $error("error transfer without halting the parser");

   a_format_sets_have: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_FORMAT) |-> have_ff)
      else $error("format transfer without a stored format");

endmodule
